### hdl/djd_pkg.sv
// ----------------------------------------------------------------------------
// djd_pkg
// Shared types, constants and small tables for the Julian day number
// date calculator pipeline.
// ----------------------------------------------------------------------------
package djd_pkg;

  // Pipeline depth of the two halves.
  localparam int FRONT_STG = 4;
  localparam int BACK_STG  = 10;
  localparam int STAGES    = FRONT_STG + BACK_STG;

  // Validation.
  localparam logic signed [14:0] YEAR_MIN  = -15'sd4712;
  localparam logic [15:0]        YEAR_BIAS = 16'd4800;
  localparam logic [3:0]         MONTH_JAN = 4'd1;
  localparam logic [3:0]         MONTH_FEB = 4'd2;
  localparam logic [3:0]         MONTH_DEC = 4'd12;
  localparam logic [3:0]         DEF_MONTH = 4'd5;
  localparam logic [4:0]         DEF_DAY   = 5'd11;
  localparam logic [14:0]        DEF_YP    = 15'd6759;   // 1959 + 4800
  localparam logic [8:0]         DEF_ORDINAL = 9'd131;   // 11 May
  // Multiplicative inverse of 25 modulo 2**15 and the divisibility bound.
  localparam logic [14:0]        INV25     = 15'd23593;
  localparam logic [14:0]        DIV25_LIM = 15'd1310;

  // Date to day number.
  localparam logic [10:0] C_JY     = 11'd1461;
  localparam logic [23:0] JDN_BIAS = 24'd32075;

  // Day number to date.
  localparam logic [25:0] L_BIAS   = 26'd68569;
  localparam logic [25:0] L_LOW    = 26'd68607;    // day number 38 plus bias
  localparam logic [25:0] L_HIGH   = 26'd5442053;  // day number 5373484 plus bias
  localparam logic [17:0] C_CYCLE  = 18'd146097;
  localparam logic [11:0] C_I      = 12'd4000;
  localparam logic [11:0] C_MD     = 12'd2447;
  localparam logic [6:0]  C_80     = 7'd80;
  localparam logic [6:0]  C_100    = 7'd100;
  localparam logic [16:0] Y_OFS    = 17'd4900;

  // Reciprocals for division by constants: q = (x * M) >> S, exact because
  // the largest x times the divisor stays below 2**S.
  localparam int S_100 = 22;
  localparam int S_7   = 26;
  localparam int S_N   = 43;
  localparam int S_I   = 51;
  localparam int S_J   = 27;
  localparam int S_K   = 22;
  localparam logic [63:0] M_100 = ((64'd1 << S_100) + 64'd99) / 64'd100;
  localparam logic [63:0] M_7   = ((64'd1 << S_7) + 64'd6) / 64'd7;
  localparam logic [63:0] M_N   = ((64'd1 << S_N) + 64'd146096) / 64'd146097;
  localparam logic [63:0] M_I   = ((64'd1 << S_I) + 64'd1461000) / 64'd1461001;
  localparam logic [63:0] M_J   = ((64'd1 << S_J) + 64'd2446) / 64'd2447;
  localparam logic [63:0] M_K   = ((64'd1 << S_K) + 64'd79) / 64'd80;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [14:0] yp;      // year plus 4800
    logic        leap;
    logic        ok;
  } date_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [22:0] t1q;     // 1461 * year / 4
    logic [7:0]  q100;    // century count
    logic [8:0]  mterm;   // 367 * month / 12 term
  } part_t;

  typedef struct packed {
    logic [22:0] l;
    logic        oor;
    logic [22:0] diff;
    logic [8:0]  ordinal;
    logic        a_valid;
    logic [2:0]  ja_lo;
    logic [2:0]  q7_lo;
  } front_t;

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] month_term(logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Validates a date and substitutes 11 May 1959 when it is rejected.
  function automatic date_t check_date(logic [3:0] m, logic [4:0] d,
                                       logic signed [14:0] y);
    logic [15:0] yp16;
    logic [29:0] prod;
    logic        div25;
    logic        leap;
    logic        ok;
    date_t       r;
    yp16  = {y[14], y} + YEAR_BIAS;
    prod  = 30'(yp16[14:0]) * 30'(INV25);
    div25 = (prod[14:0] <= DIV25_LIM);
    leap  = (yp16[1:0] == 2'd0) && (!div25 || (yp16[3:0] == 4'd0));
    ok    = (m >= MONTH_JAN) && (m <= MONTH_DEC) && (d != 5'd0) &&
            (y >= YEAR_MIN) && (d <= month_days(m, leap));
    r.month = ok ? m : DEF_MONTH;
    r.day   = ok ? d : DEF_DAY;
    r.yp    = ok ? yp16[14:0] : DEF_YP;
    r.leap  = ok && leap;
    r.ok    = ok;
    return r;
  endfunction

  // Products of the day number formula; both multipliers work in parallel.
  function automatic part_t jdn_part(date_t dt);
    logic [14:0] yq;
    logic [14:0] x;
    logic [25:0] t1;
    logic [30:0] pq;
    part_t       p;
    yq      = dt.yp - ((dt.month <= MONTH_FEB) ? 15'd1 : 15'd0);
    t1      = 26'(yq) * 26'(C_JY);
    x       = yq + 15'(C_100);
    pq      = 31'(x) * 31'(M_100);
    p.day   = dt.day;
    p.t1q   = t1[24:2];
    p.q100  = pq[S_100 +: 8];
    p.mterm = month_term(dt.month);
    return p;
  endfunction

  function automatic logic [22:0] jdn_sum(part_t p);
    logic [9:0]  t3;
    logic [23:0] s;
    t3 = 10'(p.q100) * 10'd3;
    s  = 24'(p.day) + 24'(p.t1q) + 24'(p.mterm) - 24'(t3[9:2]) - JDN_BIAS;
    return s[22:0];
  endfunction

endpackage

### hdl/djd_front.sv
// ----------------------------------------------------------------------------
// djd_front
// Validates both dates, converts them to day numbers and forms the shifted
// day number, the distance, the ordinal day and the weekday quotient.
// ----------------------------------------------------------------------------
module djd_front (
  input  logic                           clk,
  input  logic [djd_pkg::FRONT_STG-1:0]  en,
  input  logic [3:0]                     month_a,
  input  logic [4:0]                     day_a,
  input  logic signed [14:0]             year_a,
  input  logic signed [23:0]             day_offset,
  input  logic [3:0]                     month_b,
  input  logic [4:0]                     day_b,
  input  logic signed [14:0]             year_b,
  output djd_pkg::front_t                res
);
  import djd_pkg::*;

  date_t              s1_a, s1_b;
  logic signed [23:0] s1_off;
  part_t              s2_a, s2_b;
  logic [8:0]         s2_ord;
  logic               s2_valid;
  logic signed [23:0] s2_off;
  logic [22:0]        s3_ja, s3_jb;
  logic [8:0]         s3_ord;
  logic               s3_valid;
  logic signed [23:0] s3_off;

  logic signed [25:0] l_s;
  logic [46:0]        pw;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_a   <= check_date(month_a, day_a, year_a);
      s1_b   <= check_date(month_b, day_b, year_b);
      s1_off <= day_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_a     <= jdn_part(s1_a);
      s2_b     <= jdn_part(s1_b);
      s2_ord   <= days_before(s1_a.month) + 9'(s1_a.day) +
                  9'(s1_a.leap && (s1_a.month > MONTH_FEB));
      s2_valid <= s1_a.ok;
      s2_off   <= s1_off;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_ja    <= jdn_sum(s2_a);
      s3_jb    <= jdn_sum(s2_b);
      s3_ord   <= s2_ord;
      s3_valid <= s2_valid;
      s3_off   <= s2_off;
    end
  end

  // The bias of the inverse formula is folded into the shifted day number.
  assign l_s = $signed({3'b000, s3_ja}) + $signed({{2{s3_off[23]}}, s3_off}) +
               $signed(L_BIAS);
  assign pw  = 47'(s3_ja) * 47'(M_7);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      res.l       <= l_s[22:0];
      res.oor     <= (l_s < $signed(L_LOW)) || (l_s > $signed(L_HIGH));
      res.diff    <= (s3_ja > s3_jb) ? (s3_ja - s3_jb) : (s3_jb - s3_ja);
      res.ordinal <= s3_ord;
      res.a_valid <= s3_valid;
      res.ja_lo   <= s3_ja[2:0];
      res.q7_lo   <= pw[S_7 +: 3];
    end
  end

endmodule

### hdl/djd_back.sv
// ----------------------------------------------------------------------------
// djd_back
// Converts the shifted day number back to a calendar date and carries the
// other results alongside; the last stage is the output register.
// ----------------------------------------------------------------------------
module djd_back (
  input  logic                          clk,
  input  logic [djd_pkg::BACK_STG-1:0]  en,
  input  djd_pkg::front_t               fin,
  output logic [3:0]                    shifted_month,
  output logic [4:0]                    shifted_day,
  output logic signed [14:0]            shifted_year,
  output logic                          shift_out_of_range,
  output logic [22:0]                   days_apart,
  output logic [8:0]                    ordinal_day,
  output logic [2:0]                    weekday,
  output logic                          a_was_valid
);
  import djd_pkg::*;

  typedef struct packed {
    logic        oor;
    logic [22:0] diff;
    logic [8:0]  ordinal;
    logic        a_valid;
    logic [2:0]  weekday;
  } side_t;

  side_t       sb [BACK_STG-1];

  logic [22:0] b1_l, b2_l;
  logic [7:0]  b1_n, b2_n, b3_n, b4_n, b5_n, b6_n, b7_n, b8_n, b9_n;
  logic [23:0] b2_sub;
  logic [17:0] b3_l2, b4_l2, b5_l2;
  logic [29:0] b3_n5;
  logic [8:0]  b4_i, b5_i, b6_i, b7_i, b8_i, b9_i;
  logic [17:0] b5_sub;
  logic [8:0]  b6_l3, b7_l3, b8_l3, b9_l3;
  logic [14:0] b6_n7;
  logic [3:0]  b7_j, b8_j, b9_j;
  logic [14:0] b8_p8;
  logic [8:0]  b9_q;

  logic [50:0] p1;
  logic [25:0] p2;
  logic [22:0] l2_full;
  logic [60:0] p5;
  logic [19:0] p6;
  logic [17:0] l3_full;
  logic [30:0] p7;
  logic [30:0] p9;
  logic        l4;
  logic [16:0] year_s;

  // Side results ride along; the weekday uses ja - 7q = ja + q modulo 8.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sb[0].oor     <= fin.oor;
      sb[0].diff    <= fin.diff;
      sb[0].ordinal <= fin.ordinal;
      sb[0].a_valid <= fin.a_valid;
      sb[0].weekday <= fin.ja_lo + fin.q7_lo;
    end
    for (int k = 1; k < BACK_STG - 1; k++) begin
      if (en[k]) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  assign p1      = 51'({fin.l, 2'b00}) * 51'(M_N);
  assign p2      = 26'(b1_n) * 26'(C_CYCLE) + 26'd3;
  assign l2_full = b2_l - b2_sub[22:0];
  assign p5      = 61'(b3_n5) * 61'(M_I);
  assign p6      = 20'(b4_i) * 20'(C_JY);
  assign l3_full = b5_l2 - b5_sub + 18'd31;
  assign p7      = 31'(b6_n7) * 31'(M_J);
  assign p9      = 31'(b8_p8) * 31'(M_K);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1_l <= fin.l;
      b1_n <= p1[S_N +: 8];
    end
    if (en[1]) begin
      b2_l   <= b1_l;
      b2_n   <= b1_n;
      b2_sub <= 24'(p2[25:2]);
    end
    if (en[2]) begin
      b3_l2 <= l2_full[17:0];
      b3_n5 <= 30'(l2_full[17:0] + 18'd1) * 30'(C_I);
      b3_n  <= b2_n;
    end
    if (en[3]) begin
      b4_i  <= p5[S_I +: 9];
      b4_l2 <= b3_l2;
      b4_n  <= b3_n;
    end
    if (en[4]) begin
      b5_sub <= p6[19:2];
      b5_l2  <= b4_l2;
      b5_i   <= b4_i;
      b5_n   <= b4_n;
    end
    if (en[5]) begin
      b6_l3 <= l3_full[8:0];
      b6_n7 <= 15'(l3_full[8:0]) * 15'(C_80);
      b6_i  <= b5_i;
      b6_n  <= b5_n;
    end
    if (en[6]) begin
      b7_j  <= p7[S_J +: 4];
      b7_l3 <= b6_l3;
      b7_i  <= b6_i;
      b7_n  <= b6_n;
    end
    if (en[7]) begin
      b8_p8 <= 15'(b7_j) * 15'(C_MD);
      b8_j  <= b7_j;
      b8_l3 <= b7_l3;
      b8_i  <= b7_i;
      b8_n  <= b7_n;
    end
    if (en[8]) begin
      b9_q  <= p9[S_K +: 9];
      b9_j  <= b8_j;
      b9_l3 <= b8_l3;
      b9_i  <= b8_i;
      b9_n  <= b8_n;
    end
  end

  // January and February count as months 11 and 12 of the previous year.
  assign l4     = (b9_j >= 4'd11);
  assign year_s = 17'(b9_n) * 17'(C_100) - Y_OFS + 17'(b9_i) + 17'(l4);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      shift_out_of_range <= sb[BACK_STG-2].oor;
      days_apart         <= sb[BACK_STG-2].diff;
      ordinal_day        <= sb[BACK_STG-2].ordinal;
      a_was_valid        <= sb[BACK_STG-2].a_valid;
      weekday            <= sb[BACK_STG-2].weekday;
      if (sb[BACK_STG-2].oor) begin
        shifted_month <= 4'd0;
        shifted_day   <= 5'd0;
        shifted_year  <= 15'sd0;
      end else begin
        shifted_month <= b9_j + 4'd2 - (l4 ? 4'd12 : 4'd0);
        shifted_day   <= 5'(b9_l3 - b9_q);
        shifted_year  <= $signed(year_s[14:0]);
      end
    end
  end

endmodule

### hdl/date_julian_day_calculator.sv
// ----------------------------------------------------------------------------
// date_julian_day_calculator
// Gregorian date arithmetic on Julian day numbers: date plus offset,
// distance between two dates, day of year and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) takes one word holding date A,
//   a signed day offset and date B. Each word yields exactly one output word
//   on the output channel (out_valid / out_ready), in order.
//   Invalid dates are replaced by 11 May 1959; a_was_valid reports it for A.
//   When A plus the offset leaves 1 Jan -4712 .. 31 Dec 9999 the shifted
//   date reads as zero and shift_out_of_range is set.
//   The pipeline has 14 register stages; out_valid is the valid bit of the
//   last one. Throughput is one word per cycle as long as the receiver
//   takes words. The depth is set by the chain of constant divisions, each
//   a reciprocal multiply followed by a register.
//   Every stage has its own valid bit and holds when the stage after it is
//   full and blocked, so a stalled receiver fills empty stages first and
//   in_ready drops only when all 14 stages hold words.
//   Reset (rst, synchronous) empties the pipeline; no data is cleared.
// ----------------------------------------------------------------------------
module date_julian_day_calculator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         month_a,
  input  logic [4:0]         day_a,
  input  logic signed [14:0] year_a,
  input  logic signed [23:0] day_offset,
  input  logic [3:0]         month_b,
  input  logic [4:0]         day_b,
  input  logic signed [14:0] year_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         shifted_month,
  output logic [4:0]         shifted_day,
  output logic signed [14:0] shifted_year,
  output logic               shift_out_of_range,
  output logic [22:0]        days_apart,
  output logic [8:0]         ordinal_day,
  output logic [2:0]         weekday,
  output logic               a_was_valid
);
  import djd_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;
  front_t            mid;

  // A stage may load when it or any stage after it is empty, or when the
  // receiver takes the output word.
  for (genvar g = 0; g < STAGES; g++) begin : g_en
    assign en[g] = out_ready || !(&vld[STAGES-1:g]);
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  djd_front u_front (
    .clk        (clk),
    .en         (en[FRONT_STG-1:0]),
    .month_a    (month_a),
    .day_a      (day_a),
    .year_a     (year_a),
    .day_offset (day_offset),
    .month_b    (month_b),
    .day_b      (day_b),
    .year_b     (year_b),
    .res        (mid)
  );

  djd_back u_back (
    .clk                (clk),
    .en                 (en[STAGES-1:FRONT_STG]),
    .fin                (mid),
    .shifted_month      (shifted_month),
    .shifted_day        (shifted_day),
    .shifted_year       (shifted_year),
    .shift_out_of_range (shift_out_of_range),
    .days_apart         (days_apart),
    .ordinal_day        (ordinal_day),
    .weekday            (weekday),
    .a_was_valid        (a_was_valid)
  );

  // Back pressure reaches the input only once every stage is occupied.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld))
    else $error("input stalled while the pipeline has an empty stage");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && shift_out_of_range) |->
      (shifted_month == 4'd0 && shifted_day == 5'd0 && shifted_year == 15'sd0))
    else $error("shifted date not cleared when out of range");

  a_shift_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !shift_out_of_range) |->
      (shifted_month >= 4'd1 && shifted_month <= 4'd12 && shifted_day != 5'd0))
    else $error("shifted date malformed");

  a_calendar: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday <= 3'd6 && ordinal_day != 9'd0 && ordinal_day <= 9'd366))
    else $error("weekday or ordinal day out of range");

  a_default_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !a_was_valid) |-> (ordinal_day == DEF_ORDINAL))
    else $error("rejected date A not replaced by the default date");

endmodule
